// File: rtl/core/tamod_pkg.sv
package tamod_pkg;

	// Sizes of the phase path and the quarter-wave table
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;
	localparam int QUARTER_LEN     = 1 << (SINE_TABLE_BITS - 2);
	localparam int ROM_ADDR_W      = SINE_TABLE_BITS - 1;
	localparam int SAMPLE_W        = 16;
	localparam int MOD_W           = 25;
	localparam int INDEX_W         = 16;
	localparam int CFG_W           = 32;

	// Phase offset: |m * index| * (2^32 / 2pi) is in turns * 2^55
	localparam int OFF_SHIFT       = 55 - PHASE_BITS;
	localparam logic [31:0] TURN_PER_RAD_Q32 = 32'd683565276;
	localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;

	// Digit-serial multiplier geometry
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 32;
	localparam int MUL_DIGIT = 4;
	localparam int MUL_ACC_W = MUL_A_W + MUL_DIGIT;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_MODE         = 2'd0,
		REG_CARRIER_STEP = 2'd1,
		REG_MESSAGE_STEP = 2'd2,
		REG_MOD_INDEX    = 2'd3
	} tamod_reg_t;

	// Modulation mode codes; the spare code takes the phase path
	localparam logic [1:0] MODE_AM = 2'd0;
	localparam logic [1:0] MODE_PM = 2'd1;
	localparam logic [1:0] MODE_FM = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MSG,
		ST_PROD_GO,
		ST_PROD_WAIT,
		ST_PREP,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_AM_ROUND,
		ST_PM_OFFSET,
		ST_PM_PHASE,
		ST_PM_LOOK,
		ST_DONE
	} tamod_state_t;

	// Multiplier control and status
	typedef struct packed {
		logic       start;
		logic       last_signed;
		logic [2:0] digits_m1;
	} mul_ctl_t;

	typedef struct packed {
		logic                 done;
		logic [MUL_ACC_W-1:0] acc;
		logic [MUL_B_W-1:0]   lo;
	} mul_res_t;

	typedef logic [SAMPLE_W-1:0] sine_rom_t [0:QUARTER_LEN];

	// Quarter-wave sine in Q1.15: eight-term Taylor series in Q30
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t          r;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [64:0] sum;
		logic [64:0]        rnd;
		for (int k = 0; k <= QUARTER_LEN; k++) begin
			x    = (64'(k) * HALF_PI_Q30 + 64'(QUARTER_LEN / 2)) / 64'(QUARTER_LEN);
			x2   = (x * x) >> 30;
			term = x;
			sum  = $signed({1'b0, x});
			term = ((term * x2) >> 30) / 64'd6;
			sum  = sum - $signed({1'b0, term});
			term = ((term * x2) >> 30) / 64'd20;
			sum  = sum + $signed({1'b0, term});
			term = ((term * x2) >> 30) / 64'd42;
			sum  = sum - $signed({1'b0, term});
			term = ((term * x2) >> 30) / 64'd72;
			sum  = sum + $signed({1'b0, term});
			term = ((term * x2) >> 30) / 64'd110;
			sum  = sum - $signed({1'b0, term});
			term = ((term * x2) >> 30) / 64'd156;
			sum  = sum + $signed({1'b0, term});
			term = ((term * x2) >> 30) / 64'd210;
			sum  = sum - $signed({1'b0, term});
			if (sum < 0) begin
				sum = '0;
			end
			rnd = (65'(sum) + 65'd16384) >> 15;
			if (rnd > 65'd32767) begin
				rnd = 65'd32767;
			end
			r[k] = rnd[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/core/tone_am_pm_fm_modulator_core.sv
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata[0] restart, rest zero
// m_axis    out  48     tdata[24:0] modulated_sample, [40:25] message_sample, rest zero
// cfg       in   32     cfg_we, cfg_index (mode, carrier_step, message_step, mod_index)
//
// Each item runs two products through the shared 4-bit digit-serial multiplier:
// the message product (4 digits) and the scaling (4 digits in amplitude mode,
// 8 in phase or frequency mode) before the result enters the output register.
// Reset (arst_n low) clears both phases and loads the register reset values.
// A held result does not block the next input transfer; only an item that
// finishes while the output register is still full waits for it.
module tone_am_pm_fm_modulator_core import tamod_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [0] restart
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata,   // [24:0] modulated_sample, [40:25] message_sample
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	tamod_state_t state_q, state_d;

	logic [1:0]            mode_q;
	logic [31:0]           car_step_q;
	logic [31:0]           msg_step_q;
	logic [INDEX_W-1:0]    mod_index_q;

	logic [PHASE_BITS-1:0] car_phase_q;
	logic [PHASE_BITS-1:0] msg_phase_q;
	logic [PHASE_BITS-1:0] car_use_q;
	logic [PHASE_BITS-1:0] msg_use_q;
	logic [PHASE_BITS-1:0] pm_phase_q;
	logic [PHASE_BITS-1:0] off_q;

	logic signed [SAMPLE_W-1:0] m_val_q;
	logic signed [SAMPLE_W-1:0] cos_q;
	logic [31:0]                op_q;
	logic                       neg_q;
	logic signed [MOD_W-1:0]    res_q;

	logic                       m_tvalid_q;
	logic signed [MOD_W-1:0]    out_mod_q;
	logic signed [SAMPLE_W-1:0] out_msg_q;

	logic                       in_xfer;
	logic                       out_load;
	logic                       am_mode;
	logic [PHASE_BITS-1:0]      car_base;
	logic [PHASE_BITS-1:0]      msg_base;

	logic [PHASE_BITS-1:0]      sine_phase;
	logic                       sine_cos;
	logic signed [SAMPLE_W-1:0] sine_val;

	mul_ctl_t                   mul_ctl;
	mul_res_t                   mul_res;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]         mul_b;

	logic signed [31:0]         prod;
	logic [32:0]                prod_rnd;
	logic signed [MOD_W-1:0]    env;
	logic [40:0]                am_rnd;
	logic [54:0]                pm_rnd;

	assign in_xfer = s_tvalid && s_tready;
	assign am_mode = (mode_q == MODE_AM);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_AM;
			car_step_q  <= 32'd536870912;
			msg_step_q  <= 32'd26843546;
			mod_index_q <= 16'd128;
		end else if (cfg_we) begin
			unique case (tamod_reg_t'(cfg_index))
				REG_MODE:         mode_q      <= cfg_data[1:0];
				REG_CARRIER_STEP: car_step_q  <= cfg_data[31:0];
				REG_MESSAGE_STEP: msg_step_q  <= cfg_data[31:0];
				REG_MOD_INDEX:    mod_index_q <= cfg_data[INDEX_W-1:0];
			endcase
		end
	end

	// Phase accumulators: restart zeroes them before this tick
	assign car_base = s_tdata[0] ? '0 : car_phase_q;
	assign msg_base = s_tdata[0] ? '0 : msg_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_phase_q <= '0;
			msg_phase_q <= '0;
		end else if (in_xfer) begin
			car_phase_q <= car_base + PHASE_BITS'(car_step_q);
			msg_phase_q <= msg_base + PHASE_BITS'(msg_step_q);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (s_tvalid) state_d = ST_MSG;
			ST_MSG:        state_d = ST_PROD_GO;
			ST_PROD_GO:    state_d = ST_PROD_WAIT;
			ST_PROD_WAIT:  if (mul_res.done) state_d = ST_PREP;
			ST_PREP:       state_d = ST_SCALE_GO;
			ST_SCALE_GO:   state_d = ST_SCALE_WAIT;
			ST_SCALE_WAIT: begin
				if (mul_res.done) begin
					state_d = am_mode ? ST_AM_ROUND : ST_PM_OFFSET;
				end
			end
			ST_AM_ROUND:   state_d = ST_DONE;
			ST_PM_OFFSET:  state_d = ST_PM_PHASE;
			ST_PM_PHASE:   state_d = ST_PM_LOOK;
			ST_PM_LOOK:    state_d = ST_DONE;
			ST_DONE:       if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready            = 1'b0;
		out_load            = 1'b0;
		mul_ctl.start       = 1'b0;
		mul_ctl.last_signed = 1'b0;
		mul_ctl.digits_m1   = 3'd3;
		mul_a               = MUL_A_W'(m_val_q);
		mul_b               = MUL_B_W'(mod_index_q);
		sine_phase          = pm_phase_q;
		sine_cos            = 1'b1;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MSG: begin
				sine_phase = msg_use_q;
				sine_cos   = 1'b0;
			end
			ST_PROD_GO: mul_ctl.start = 1'b1;
			ST_PREP: sine_phase = car_use_q;
			ST_SCALE_GO: begin
				mul_ctl.start = 1'b1;
				if (am_mode) begin
					mul_ctl.last_signed = 1'b1;
					mul_a               = $signed(op_q);
					mul_b               = MUL_B_W'($unsigned(cos_q));
				end else begin
					mul_ctl.digits_m1 = 3'd7;
					mul_a             = $signed(TURN_PER_RAD_Q32);
					mul_b             = op_q;
				end
			end
			ST_DONE: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	tamod_sine u_sine (
		.phase   (sine_phase),
		.cos_sel (sine_cos),
		.value   (sine_val)
	);

	tamod_serial_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.res    (mul_res)
	);

	// Product views of the multiplier
	assign prod     = $signed({mul_res.acc[15:0], mul_res.lo[31:16]});
	assign prod_rnd = {prod[31], prod} + 33'd128;
	assign env      = $signed(prod_rnd[32:8]) + 25'sd32768;
	assign am_rnd   = {mul_res.acc[24:0], mul_res.lo[31:16]} + 41'd16384;
	assign pm_rnd   = {mul_res.acc[22:0], mul_res.lo} + (55'd1 << (OFF_SHIFT - 1));

	// Working registers of one item
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				car_use_q <= car_base;
				msg_use_q <= msg_base;
			end
			ST_MSG: m_val_q <= sine_val;
			ST_PREP: begin
				cos_q <= sine_val;
				neg_q <= prod[31];
				if (am_mode) begin
					op_q <= 32'(env);
				end else begin
					op_q <= prod[31] ? 32'(-prod) : 32'(prod);
				end
			end
			ST_AM_ROUND:  res_q <= $signed(am_rnd[39:15]);
			ST_PM_OFFSET: off_q <= pm_rnd[OFF_SHIFT + PHASE_BITS - 1 : OFF_SHIFT];
			ST_PM_PHASE:  pm_phase_q <= neg_q ? (car_use_q - off_q) : (car_use_q + off_q);
			ST_PM_LOOK:   res_q <= MOD_W'(sine_val);
			default: ;
		endcase
	end

	// Output register: hold the result until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mod_q <= res_q;
			out_msg_q <= m_val_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_msg_q, out_mod_q};

	// The multiplier only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_res.done |-> (state_q == ST_PROD_WAIT || state_q == ST_SCALE_WAIT))
		else $error("multiplier finished outside a wait state");

	// An accepted item starts with the message lookup
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_MSG))
		else $error("accepted item did not start");

	// A restart makes this tick time zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tdata[0]) |=> (car_use_q == '0 && msg_use_q == '0))
		else $error("restart did not zero the phases");

	// The message sine never reaches the negative full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_msg_q != 16'sh8000))
		else $error("message sample out of range");

endmodule

// File: rtl/core/tamod_sine.sv
module tamod_sine import tamod_pkg::*; (
	input  logic [PHASE_BITS-1:0]      phase,
	input  logic                       cos_sel,
	output logic signed [SAMPLE_W-1:0] value
);

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                 quad;
	logic [ROM_ADDR_W-2:0]      offs;
	logic [ROM_ADDR_W-1:0]      addr;
	logic [SAMPLE_W-1:0]        mag;

	// Take the top phase bits; a cosine is a quarter turn ahead
	assign idx  = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign quad = idx[SINE_TABLE_BITS-1 -: 2] + {1'b0, cos_sel};
	assign offs = idx[SINE_TABLE_BITS-3:0];

	// Fold into the first quadrant and read the table
	assign addr  = quad[0] ? (ROM_ADDR_W'(QUARTER_LEN) - {1'b0, offs}) : {1'b0, offs};
	assign mag   = SINE_ROM[addr];
	assign value = quad[1] ? $signed(SAMPLE_W'(-mag)) : $signed(mag);

endmodule

// File: rtl/core/tamod_serial_mult.sv
module tamod_serial_mult import tamod_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mul_ctl_t                  ctl,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0]        b,
	output mul_res_t                  res
);

	logic signed [MUL_A_W-1:0]   a_q;
	logic [MUL_B_W-1:0]          b_q;
	logic [2:0]                  cnt_q;
	logic                        busy_q;
	logic                        sgn_q;
	logic                        done_q;
	logic signed [MUL_ACC_W-1:0] acc_q;
	logic [MUL_B_W-1:0]          lo_q;

	logic                          last_digit;
	logic signed [MUL_DIGIT:0]     digit;
	logic signed [MUL_ACC_W:0]     pp;
	logic signed [MUL_ACC_W:0]     sum;

	// Current digit, the top one signed for a two's complement multiplier
	assign last_digit = (cnt_q == 3'd0);
	assign digit = (last_digit && sgn_q) ? $signed({b_q[MUL_DIGIT-1], b_q[MUL_DIGIT-1:0]})
	                                      : $signed({1'b0, b_q[MUL_DIGIT-1:0]});
	assign pp  = a_q * digit;
	assign sum = $signed({acc_q[MUL_ACC_W-1], acc_q}) + pp;

	// Control: count the digits and flag the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sgn_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.digits_m1;
				sgn_q  <= ctl.last_signed;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (last_digit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: add one partial product, shift one digit out to the low word
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
			lo_q  <= '0;
		end else if (busy_q) begin
			b_q   <= b_q >> MUL_DIGIT;
			acc_q <= {{(MUL_DIGIT - 1){sum[MUL_ACC_W]}}, sum[MUL_ACC_W:MUL_DIGIT]};
			lo_q  <= {sum[MUL_DIGIT-1:0], lo_q[MUL_B_W-1:MUL_DIGIT]};
		end
	end

	assign res.done = done_q;
	assign res.acc  = acc_q;
	assign res.lo   = lo_q;

endmodule
